// ===== rtl/gmbb_pkg.sv =====
// Shared constants, payload structs, controller state and command/status types
// for the gray mirror box blur unit. No dependencies.
package gmbb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_KERNEL  = 7;
   localparam int STORE_ROWS  = 8;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(STORE_ROWS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int KER_W       = 3;
   localparam int PIX_W       = 8;
   localparam int Q_W         = 22;
   localparam int P_W         = 21;
   localparam int TOTAL_W     = 21;
   localparam int DELAY_W     = 13;
   localparam int IDX_W       = 13;
   localparam int WSUM_W      = 15;
   localparam int SUM_W       = 14;
   localparam int DIV_W       = Q_W;
   localparam int DVSR_W      = CFG_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int GRAY_RECIP  = 5243;
   localparam int RECIP_W     = 13;
   localparam int GRAY_SHIFT  = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIDE     = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [KER_W-1:0] KERNEL_RESET = 3'd3;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blurred_value;
      logic             frame_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SYNC_Q,
      ST_SYNC_QW,
      ST_SYNC_P,
      ST_SYNC_PW,
      ST_STEP,
      ST_BOX,
      ST_BSUM,
      ST_MEAN,
      ST_MEANW,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic ready;
      logic clear_wr;
      logic q_div_start;
      logic q_div_load;
      logic p_div_start;
      logic p_div_load;
      logic step;
      logic box_issue;
      logic mean_start;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic accepted;
      logic cfg_written;
      logic clear_done;
      logic div_done;
      logic skip;
      logic emit_due;
      logic box_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/gmbb_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gmbb_pkg.
module gmbb_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gmbb_pkg::DIV_W-1:0]  dividend,
   input  logic [gmbb_pkg::DVSR_W-1:0] divisor,
   output logic                       done,
   output logic [gmbb_pkg::DIV_W-1:0]  quotient,
   output logic [gmbb_pkg::DVSR_W-1:0] remainder
);
   import gmbb_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DVSR_W:0]      trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         cnt_in  = DIV_CNT_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = DVSR_W'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVSR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/gmbb_datapath.sv =====
// Datapath: config registers, frame counters, row store, box accumulator,
// shared divider and result register. Depends on gmbb_pkg, gmbb_divider.
module gmbb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gmbb_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gmbb_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [gmbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmbb_pkg::CFG_W-1:0]     csr_wdata,
   input  gmbb_pkg::ctrl_cmd_type        cmd,
   output gmbb_pkg::dp_status_type       status
);
   import gmbb_pkg::*;

   logic [CFG_W-1:0]   cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [KER_W-1:0]   cfg_k_ff, cfg_k_in;
   logic               csr_we_ff;
   logic [CFG_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [KER_W-1:0]   k_ff, k_in;
   logic [1:0]         n_ff, n_in;
   logic [5:0]         kk_ff, kk_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;

   logic [Q_W-1:0]     q_ff, q_in, q_cur;
   logic [P_W-1:0]     p_ff, p_in, p_cur;
   logic [COL_W-1:0]   qcol_ff, qcol_in, qcol_cur;
   logic [ROW_W-1:0]   qrow_ff, qrow_in, qrow_cur;
   logic [COL_W-1:0]   pi_ff, pi_in, pi_cur, pj_ff, pj_in, pj_cur;
   logic               frame_clr, in_frame, skip, emit_due, last;

   logic               action_ff;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [WSUM_W+RECIP_W-1:0] gray_prod;
   logic [PIX_W-1:0]   gray;

   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [PIX_W-1:0]   store_mem [STORE_DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [PIX_W-1:0]   mem_wdata, rd_data_ff;
   logic               rd_tag_ff;

   logic [KER_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [IDX_W-1:0]   rr, xx, r_idx, x_idx;
   logic               pos_ok;
   logic [CFG_W-1:0]   mcol;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_quo;
   logic [DVSR_W-1:0]  div_divisor, div_rem;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // config registers
   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      cfg_k_in = cfg_k_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_w_in = csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_h_in = csr_wdata;
            CSR_BOX_SIDE:     cfg_k_in = csr_wdata[KER_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   always_comb begin
      w_in = cfg_w_ff;
      if (cfg_w_ff == '0) w_in = CFG_W'(1);
      if (cfg_w_ff > CFG_W'(MAX_WIDTH)) w_in = CFG_W'(MAX_WIDTH);
      h_in = cfg_h_ff;
      if (cfg_h_ff == '0) h_in = CFG_W'(1);
      if (cfg_h_ff > CFG_W'(MAX_HEIGHT)) h_in = CFG_W'(MAX_HEIGHT);
      k_in = cfg_k_ff;
      if (cfg_k_ff == '0) k_in = KER_W'(1);
      if (cfg_k_ff > KER_W'(MAX_KERNEL)) k_in = KER_W'(MAX_KERNEL);
      if (k_in > KER_W'(STORE_ROWS - 1)) k_in = KER_W'(STORE_ROWS - 1);
      n_in     = 2'((k_in - 1'b1) >> 1);
      kk_in    = 6'(k_in) * 6'(k_in);
      total_in = TOTAL_W'(w_ff) * TOTAL_W'(h_ff);
      delay_in = DELAY_W'(DELAY_W'(k_ff - KER_W'(n_ff)) * DELAY_W'(w_ff) - 1'b1);
   end

   // frame position for the step
   always_comb begin
      frame_clr = ({1'b0, p_ff} >= {1'b0, total_ff});
      q_cur    = frame_clr ? '0 : q_ff;
      p_cur    = frame_clr ? '0 : p_ff;
      qcol_cur = frame_clr ? '0 : qcol_ff;
      qrow_cur = frame_clr ? '0 : qrow_ff;
      pi_cur   = frame_clr ? '0 : pi_ff;
      pj_cur   = frame_clr ? '0 : pj_ff;
      in_frame = (q_cur < Q_W'(total_ff));
      skip     = in_frame && action_ff;
      emit_due = !skip && (q_cur >= (Q_W'(p_cur) + Q_W'(delay_ff)));
      last     = (p_ff == TOTAL_W'(total_ff - 1'b1));
      gray_prod = (WSUM_W+RECIP_W)'(wsum_ff) * (WSUM_W+RECIP_W)'(GRAY_RECIP);
      gray      = gray_prod[GRAY_SHIFT +: PIX_W];
   end

   always_comb begin
      q_in    = q_ff;
      p_in    = p_ff;
      qcol_in = qcol_ff;
      qrow_in = qrow_ff;
      pi_in   = pi_ff;
      pj_in   = pj_ff;
      if (cmd.q_div_load) begin
         qcol_in = div_rem[COL_W-1:0];
         qrow_in = div_quo[ROW_W-1:0];
      end
      if (cmd.p_div_load) begin
         pj_in = div_rem[COL_W-1:0];
         pi_in = div_quo[COL_W-1:0];
      end
      if (cmd.step) begin
         q_in    = q_cur;
         p_in    = p_cur;
         qcol_in = qcol_cur;
         qrow_in = qrow_cur;
         pi_in   = pi_cur;
         pj_in   = pj_cur;
         if (!skip) begin
            q_in = q_cur + 1'b1;
            if (CFG_W'(qcol_cur) == CFG_W'(w_ff - 1'b1)) begin
               qcol_in = '0;
               qrow_in = qrow_cur + 1'b1;
            end else begin
               qcol_in = qcol_cur + 1'b1;
            end
         end
      end
      if (cmd.emit) begin
         if (last) begin
            q_in    = '0;
            p_in    = '0;
            qcol_in = '0;
            qrow_in = '0;
            pi_in   = '0;
            pj_in   = '0;
         end else begin
            p_in = p_ff + 1'b1;
            if (CFG_W'(pj_ff) == CFG_W'(w_ff - 1'b1)) begin
               pj_in = '0;
               pi_in = pi_ff + 1'b1;
            end else begin
               pj_in = pj_ff + 1'b1;
            end
         end
      end
   end

   // box window walk
   always_comb begin
      rr     = IDX_W'(pi_ff) + IDX_W'(a_ff);
      xx     = IDX_W'(pj_ff) + IDX_W'(b_ff);
      r_idx  = rr - IDX_W'(n_ff);
      x_idx  = xx - IDX_W'(n_ff);
      pos_ok = (rr >= IDX_W'(n_ff)) && (r_idx < IDX_W'(h_ff))
            && (xx >= IDX_W'(n_ff)) && (x_idx < IDX_W'(w_ff));
      mcol   = CFG_W'(w_ff - 1'b1 - x_idx[CFG_W-1:0]);
      a_in   = a_ff;
      b_in   = b_ff;
      if (cmd.step) begin
         a_in = '0;
         b_in = '0;
      end else if (cmd.box_issue) begin
         if (b_ff == k_ff - 1'b1) begin
            b_in = '0;
            a_in = a_ff + 1'b1;
         end else begin
            b_in = b_ff + 1'b1;
         end
      end
      sum_in = sum_ff;
      if (cmd.step) sum_in = '0;
      else if (rd_tag_ff) sum_in = sum_ff + SUM_W'(rd_data_ff);
      mem_raddr = {r_idx[ROW_W-1:0], mcol[COL_W-1:0]};
   end

   // row store write side
   always_comb begin
      mem_we    = cmd.clear_wr || (cmd.step && in_frame && !skip);
      mem_waddr = cmd.clear_wr ? clr_addr_ff : {qrow_cur, qcol_cur};
      mem_wdata = cmd.clear_wr ? '0 : gray;
      clr_addr_in = cmd.clear_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_comb begin
      div_start    = cmd.q_div_start || cmd.p_div_start || cmd.mean_start;
      div_dividend = DIV_W'(sum_ff);
      div_divisor  = DVSR_W'(kk_ff);
      if (cmd.q_div_start) begin
         div_dividend = q_ff;
         div_divisor  = w_ff;
      end else if (cmd.p_div_start) begin
         div_dividend = DIV_W'(p_ff);
         div_divisor  = w_ff;
      end
   end

   gmbb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      wsum_in = wsum_ff;
      if (status.accepted) begin
         wsum_in = WSUM_W'(21 * WSUM_W'(req_payload.red))
                 + WSUM_W'(72 * WSUM_W'(req_payload.green))
                 + WSUM_W'(7 * WSUM_W'(req_payload.blue));
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.blurred_value = div_quo[PIX_W-1:0];
         rsp_in.frame_last    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= WIDTH_RESET;
         cfg_h_ff     <= HEIGHT_RESET;
         cfg_k_ff     <= KERNEL_RESET;
         csr_we_ff    <= 1'b0;
         q_ff         <= '0;
         p_ff         <= '0;
         qcol_ff      <= '0;
         qrow_ff      <= '0;
         pi_ff        <= '0;
         pj_ff        <= '0;
         clr_addr_ff  <= '0;
         rd_tag_ff    <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         cfg_k_ff     <= cfg_k_in;
         csr_we_ff    <= csr_we;
         q_ff         <= q_in;
         p_ff         <= p_in;
         qcol_ff      <= qcol_in;
         qrow_ff      <= qrow_in;
         pi_ff        <= pi_in;
         pj_ff        <= pj_in;
         clr_addr_ff  <= clr_addr_in;
         rd_tag_ff    <= cmd.box_issue && pos_ok;
         a_ff         <= a_in;
         b_ff         <= b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff     <= w_in;
      h_ff     <= h_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      kk_ff    <= kk_in;
      total_ff <= total_in;
      delay_ff <= delay_in;
      sum_ff   <= sum_in;
      wsum_ff  <= wsum_in;
      rsp_ff   <= rsp_in;
      if (status.accepted) action_ff <= req_payload.action;
   end

   assign req_stall   = !(cmd.ready && !csr_we && !csr_we_ff);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      status.accepted    = req_valid && !req_stall;
      status.cfg_written = csr_we_ff;
      status.clear_done  = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));
      status.div_done    = div_done;
      status.skip        = skip;
      status.emit_due    = emit_due;
      status.box_last    = (a_ff == k_ff - 1'b1) && (b_ff == k_ff - 1'b1);
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== rtl/gmbb_ctrl.sv =====
// Controller state machine: clear pass, resync after config writes,
// per-beat step, box walk, mean division and result hand-off. Depends on gmbb_pkg.
module gmbb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  gmbb_pkg::dp_status_type status,
   output gmbb_pkg::ctrl_cmd_type  cmd
);
   import gmbb_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           dirty_ff, dirty_in;

   always_comb begin
      state_in = state_ff;
      dirty_in = status.cfg_written || (dirty_ff && (state_ff != ST_SYNC_Q));
      case (state_ff)
         ST_CLEAR:   if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (dirty_ff) state_in = ST_SYNC_Q;
            else if (status.accepted) state_in = ST_STEP;
         end
         ST_SYNC_Q:  state_in = ST_SYNC_QW;
         ST_SYNC_QW: if (status.div_done) state_in = ST_SYNC_P;
         ST_SYNC_P:  state_in = ST_SYNC_PW;
         ST_SYNC_PW: if (status.div_done) state_in = ST_IDLE;
         ST_STEP: begin
            if (status.emit_due) state_in = ST_BOX;
            else state_in = ST_IDLE;
         end
         ST_BOX:     if (status.box_last) state_in = ST_BSUM;
         ST_BSUM:    state_in = ST_MEAN;
         ST_MEAN:    state_in = ST_MEANW;
         ST_MEANW:   if (status.div_done) state_in = ST_OUT;
         ST_OUT:     if (status.rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.ready       = (state_ff == ST_IDLE) && !dirty_ff;
      cmd.clear_wr    = (state_ff == ST_CLEAR);
      cmd.q_div_start = (state_ff == ST_SYNC_Q);
      cmd.q_div_load  = (state_ff == ST_SYNC_QW) && status.div_done;
      cmd.p_div_start = (state_ff == ST_SYNC_P);
      cmd.p_div_load  = (state_ff == ST_SYNC_PW) && status.div_done;
      cmd.step        = (state_ff == ST_STEP);
      cmd.box_issue   = (state_ff == ST_BOX);
      cmd.mean_start  = (state_ff == ST_MEAN);
      cmd.emit        = (state_ff == ST_OUT) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         dirty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end

endmodule

// ===== rtl/gray_mirror_box_blur_unit.sv =====
// Top level of the gray mirror box blur unit: controller plus datapath.
// Depends on gmbb_pkg, gmbb_ctrl, gmbb_datapath.
//
// Input beats (req_*) carry BGR pixels in raster order, or drain beats
// (action=1) after the frame to flush the last rows. Each accepted beat
// yields zero or one result beat on rsp_*; frame_last marks the final one.
// csr_* writes image_width, image_height and the box side; write only while
// no beat is in progress.
// Sequence: a beat with no result is accepted, then updates the frame position. A beat
// with a result also reads the row store one window pixel per cycle, then the
// shared 22-step divider forms the mean.
// After any csr write the frame position is re-derived by two divider passes
// before the next beat is taken.
// Reset: the 8192-byte row store is zeroed, one byte per cycle, with req_stall
// high; csr writes are taken meanwhile.
// A stalled result stays in the output register; the next beat is still
// accepted and processed up to the point where its own result would load.
module gray_mirror_box_blur_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gmbb_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gmbb_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [gmbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmbb_pkg::CFG_W-1:0]     csr_wdata
);
   import gmbb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   gmbb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   gmbb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== tb/sv/gmbb_frame_checker.sv =====
`timescale 1ns / 1ps
// Watches the req/rsp/csr ports of gray_mirror_box_blur_unit, predicts every
// result beat from its own copy of the row store and compares. Uses gmbb_pkg.
module gmbb_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  gmbb_pkg::req_type              req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  gmbb_pkg::rsp_type              rsp_payload,
   input  logic                           csr_we,
   input  logic [gmbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmbb_pkg::CFG_W-1:0]     csr_wdata,
   output int                             error_count,
   output int                             pending_count,
   output int                             frames_done,
   output int                             results_seen
);
   import gmbb_pkg::*;

   logic [PIX_W-1:0] gray_rows [STORE_DEPTH];
   rsp_type          blur_queue [$];
   int unsigned      in_cnt, out_cnt;
   logic [CFG_W-1:0] width_reg, height_reg;
   logic [KER_W-1:0] kernel_reg;
   int               errors, frames, results;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int unsigned store_index(int unsigned row, int unsigned col);
      return ((row % STORE_ROWS) * MAX_WIDTH + col) % STORE_DEPTH;
   endfunction

   function automatic logic [PIX_W-1:0] box_mean(int unsigned p, int unsigned w,
                                                 int unsigned h, int unsigned k);
      int          n, i, j, r, x;
      int unsigned sum;
      n = (k - 1) / 2;
      i = p / w;
      j = p % w;
      sum = 0;
      for (int a = 0; a < k; a++) begin
         r = i - n + a;
         if (r < 0 || r >= h) continue;
         for (int b = 0; b < k; b++) begin
            x = j - n + b;
            if (x < 0 || x >= w) continue;
            sum += gray_rows[store_index(r, w - 1 - x)];
         end
      end
      return PIX_W'(sum / (k * k));
   endfunction

   task automatic predict_beat(input req_type beat);
      int unsigned w, h, k, n, total, delay, q, p;
      rsp_type     exp_rsp;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      k = (kernel_reg == 0) ? 1 : kernel_reg;
      if (k > MAX_KERNEL) k = MAX_KERNEL;
      if (k > STORE_ROWS - 1) k = STORE_ROWS - 1;
      n = (k - 1) / 2;
      total = w * h;
      delay = (k - n) * w - 1;
      if (out_cnt >= total) begin
         in_cnt = 0;
         out_cnt = 0;
      end
      q = in_cnt;
      if (q < total) begin
         if (beat.action) return;
         gray_rows[store_index(q / w, q % w)] =
            PIX_W'((21 * beat.red + 72 * beat.green + 7 * beat.blue) / 100);
      end
      if (in_cnt != 32'hFFFF_FFFF) in_cnt++;
      p = out_cnt;
      if (q >= delay && q - delay >= p) begin
         exp_rsp.blurred_value = box_mean(p, w, h, k);
         exp_rsp.frame_last = (p == total - 1);
         blur_queue.push_back(exp_rsp);
         if (exp_rsp.frame_last) begin
            in_cnt = 0;
            out_cnt = 0;
            frames++;
         end else begin
            out_cnt++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         foreach (gray_rows[a]) gray_rows[a] = '0;
         blur_queue.delete();
         in_cnt = 0;
         out_cnt = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         kernel_reg = KERNEL_RESET;
         errors = 0;
         frames = 0;
         results = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: width_reg = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               CSR_BOX_SIDE: kernel_reg = csr_wdata[KER_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_beat(req_payload);
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (blur_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat value %0d last %0b",
                                         rsp_payload.blurred_value,
                                         rsp_payload.frame_last));
            end else begin
               exp_rsp = blur_queue.pop_front();
               if (rsp_payload.blurred_value !== exp_rsp.blurred_value)
                  report_mismatch($sformatf("blurred_value got %0d want %0d",
                                            rsp_payload.blurred_value,
                                            exp_rsp.blurred_value));
               if (rsp_payload.frame_last !== exp_rsp.frame_last)
                  report_mismatch($sformatf("frame_last got %0b want %0b",
                                            rsp_payload.frame_last,
                                            exp_rsp.frame_last));
            end
         end
      end
      error_count <= errors;
      pending_count <= blur_queue.size();
      frames_done <= frames;
      results_seen <= results;
   end

   final begin
      if (blur_queue.size() != 0) $display("%0d result beats never arrived", blur_queue.size());
   end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for gray_mirror_box_blur_unit: frames of BGR beats,
// drains, csr settings and idling. Depends on gmbb_pkg, gray_mirror_box_blur_unit and gmbb_frame_checker.
module tb_top;
   import gmbb_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 120;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   rsp_type              rsp_payload;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int error_count, pending_count, frames_done, results_seen;
   int beats_sent;
   int stall_cycles = 0;
   bit quiet;
   int hold_tag;
   int hold_seen = 0;

   always #5 clock = ~clock;

   gray_mirror_box_blur_unit u_top (.*);

   gmbb_frame_checker u_checker (.*);

   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         rsp_stall <= 1;
         stall_cycles <= stall_cycles - 1;
      end else if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         stall_cycles <= 400;
         rsp_stall <= 1;
      end else if (quiet) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 23);
      end
   end

   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", idle_cycles);
         $display("FAIL gray_mirror_box_blur_unit");
         $finish;
      end
   end

   function automatic req_type pixel_beat();
      req_type b;
      b.action = 1'b0;
      if ($urandom_range(9) == 0) begin
         b.blue = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         b.green = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         b.red = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      end else begin
         b.blue = 8'($urandom);
         b.green = 8'($urandom);
         b.red = 8'($urandom);
      end
      return b;
   endfunction

   task automatic send_beat(input req_type b);
      if (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic set_frame(input int w, input int h, input int k);
      csr_write(CSR_IMAGE_WIDTH, CFG_W'(w));
      csr_write(CSR_IMAGE_HEIGHT, CFG_W'(h));
      csr_write(CSR_BOX_SIDE, CFG_W'(k));
      csr_we <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Full frame: pixels with a few ignored early drains, then exactly enough drains.
   task automatic run_frame(input int w, input int h, input int k);
      int ew, eh, ek, total, delay;
      req_type b;
      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      ek = (k == 0) ? 1 : k;
      total = ew * eh;
      delay = (ek - (ek - 1) / 2) * ew - 1;
      set_frame(w, h, k);
      for (int q = 0; q < total; q++) begin
         if ($urandom_range(19) == 0) begin
            b = pixel_beat();
            b.action = 1'b1;
            send_beat(b);
         end
         send_beat(pixel_beat());
      end
      for (int d = 0; d < delay; d++) begin
         b = pixel_beat();
         b.action = $urandom_range(1);
         send_beat(b);
      end
      wait_idle();
   endtask

   // One beat at a time until the frame in progress has ended.
   task automatic finish_frame();
      int start;
      start = frames_done;
      for (int a = 0; a < 300 && frames_done == start; a++) begin
         send_beat(pixel_beat());
         req_valid <= 0;
         repeat (3) @(posedge clock);
      end
      wait_idle();
   endtask

   initial begin
      req_type b;
      int w, h, k;
      quiet = 0;
      hold_tag = 0;
      beats_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed 4x3 frame, 3x3 box, extreme colors and an ignored early drain
      set_frame(4, 3, 3);
      csr_write(CSR_UNUSED_INDEX, 11'h7FF);
      csr_we <= 0;
      b = '0;
      b.action = 1'b1;
      send_beat(b);
      for (int q = 0; q < 12; q++) begin
         b = '0;
         case (q)
            1: b = {1'b0, 8'hFF, 8'hFF, 8'hFF};
            2: b.red = 8'hFF;
            3: b.green = 8'hFF;
            4: b.blue = 8'hFF;
            5: b = {1'b0, 8'h55, 8'hAA, 8'h55};
            6: b = {1'b0, 8'hAA, 8'h55, 8'hAA};
            default: if (q > 6) b = pixel_beat();
         endcase
         send_beat(b);
      end
      for (int d = 0; d < 7; d++) begin
         b = pixel_beat();
         b.action = d[0];
         send_beat(b);
      end
      wait_idle();

      run_frame(1, 1, 1);
      run_frame(0, 0, 0);
      run_frame(3, 4, 7);
      run_frame(1, 2047, 7);

      // mid-frame settings: one that ends the frame at once, one that does not
      set_frame(6, 6, 1);
      repeat (20) send_beat(pixel_beat());
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, CFG_W'(2));
      csr_we <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      finish_frame();
      set_frame(6, 6, 3);
      repeat (10) send_beat(pixel_beat());
      wait_idle();
      csr_write(CSR_BOX_SIDE, CFG_W'(5));
      csr_write(CSR_IMAGE_HEIGHT, CFG_W'(2));
      csr_we <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      finish_frame();

      begin
         int base, nframe;
         base = beats_sent;
         nframe = 0;
         while (beats_sent - base < 760) begin
            w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
            k = $urandom_range(7);
            quiet = (nframe >= 8 && nframe < 14);
            if (nframe == 4) hold_tag++;
            run_frame(w, h, k);
            nframe++;
         end
      end
      quiet = 0;

      wait_idle();
      $display("Covered %0d frames over %0d input beats; %0d result beats checked",
               frames_done, beats_sent, results_seen);
      if (error_count == 0)
         $display("PASS gray_mirror_box_blur_unit");
      else
         $display("FAIL gray_mirror_box_blur_unit");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/gmbb_pkg.sv
rtl/gmbb_divider.sv
rtl/gmbb_datapath.sv
rtl/gmbb_ctrl.sv
rtl/gray_mirror_box_blur_unit.sv
tb/sv/gmbb_frame_checker.sv
tb/sv/tb_top.sv
